// ----- sv/rqce_pkg.sv -----
// Shared constants, types and the monomial table of the ray quartic expansion block.
package rqce_pkg;

  localparam int NUM_COEFS      = 35;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int TERM_N         = 5;
  localparam int LIMB_W         = 32;
  localparam int LIMB_N         = 6;
  localparam int ACC_W          = LIMB_W * LIMB_N;
  localparam int OUT_W          = 64;
  localparam int FRAC_DROP      = 48;
  localparam int TOL_W          = 33;
  localparam int COORD_W        = 32;
  localparam int PROD_W         = 65;

  localparam logic [TOL_W-1:0]   TOL_RESET = 33'd4294967;
  localparam logic [COORD_W-1:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [OUT_W-1:0]   SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0]   SAT_MIN   = 64'h8000_0000_0000_0000;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RAY  = 1'b1;

  typedef logic [1:0] mono_var_t;

  localparam mono_var_t VX = 2'd0;
  localparam mono_var_t VY = 2'd1;
  localparam mono_var_t VZ = 2'd2;
  localparam mono_var_t VW = 2'd3;

  // Each coefficient's monomial as four linear factors; the homogeneous
  // variable stands for a constant one with no direction part.
  localparam mono_var_t MONO_VAR [NUM_COEFS][4] = '{
    '{VX, VX, VX, VX}, '{VX, VX, VX, VY}, '{VX, VX, VX, VZ}, '{VX, VX, VX, VW},
    '{VX, VX, VY, VY}, '{VX, VX, VY, VZ}, '{VX, VX, VY, VW}, '{VX, VX, VZ, VZ},
    '{VX, VX, VZ, VW}, '{VX, VX, VW, VW}, '{VX, VY, VY, VY}, '{VX, VY, VY, VZ},
    '{VX, VY, VY, VW}, '{VX, VY, VZ, VZ}, '{VX, VY, VZ, VW}, '{VX, VY, VW, VW},
    '{VX, VZ, VZ, VZ}, '{VX, VZ, VZ, VW}, '{VX, VZ, VW, VW}, '{VX, VW, VW, VW},
    '{VY, VY, VY, VY}, '{VY, VY, VY, VZ}, '{VY, VY, VY, VW}, '{VY, VY, VZ, VZ},
    '{VY, VY, VZ, VW}, '{VY, VY, VW, VW}, '{VY, VZ, VZ, VZ}, '{VY, VZ, VZ, VW},
    '{VY, VZ, VW, VW}, '{VY, VW, VW, VW}, '{VZ, VZ, VZ, VZ}, '{VZ, VZ, VZ, VW},
    '{VZ, VZ, VW, VW}, '{VZ, VW, VW, VW}, '{VW, VW, VW, VW}
  };

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FETCH = 9'b000000010,
    ST_COEF  = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DRAIN = 9'b000010000,
    ST_WB    = 9'b000100000,
    ST_ACC   = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

endpackage

// ----- sv/rqce_if.sv -----
// Handshake channel interfaces for ray items, result items and the tolerance register.
interface rqce_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  logic [5:0]          coef_index;
  logic signed [31:0]  coef_value;
  logic signed [31:0]  origin_x;
  logic signed [31:0]  origin_y;
  logic signed [31:0]  origin_z;
  logic signed [31:0]  dir_x;
  logic signed [31:0]  dir_y;
  logic signed [31:0]  dir_z;

  modport source (output valid, action, coef_index, coef_value, origin_x, origin_y,
                  origin_z, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, action, coef_index, coef_value, origin_x, origin_y,
                  origin_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rqce_out_if;
  logic                valid;
  logic                ready;
  logic signed [63:0]  quartic_term;
  logic signed [63:0]  cubic_term;
  logic signed [63:0]  quadratic_term;
  logic signed [63:0]  linear_term;
  logic signed [63:0]  constant_term;
  logic                inside_res;
  logic                overflow;

  modport source (output valid, quartic_term, cubic_term, quadratic_term, linear_term,
                  constant_term, inside_res, overflow, input ready);
  modport sink   (input valid, quartic_term, cubic_term, quadratic_term, linear_term,
                  constant_term, inside_res, overflow, output ready);
endinterface

interface rqce_cfg_if;
  logic        valid;
  logic        ready;
  logic [32:0] inside_tolerance;

  modport source (output valid, inside_tolerance, input ready);
  modport sink   (input valid, inside_tolerance, output ready);
endinterface

// ----- sv/rqce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rqce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rqce_mul.sv -----
// Shared registered signed multiplier: one limb times one coordinate per cycle while en is high.
module rqce_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rqce_pkg::LIMB_W:0]   a,
  input  logic signed [rqce_pkg::COORD_W-1:0] b,
  output logic signed [rqce_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

// ----- sv/ray_quartic_coefficient_expand_core.sv -----
// Top level of the ray quartic expansion block: sequencer, coefficient store and datapath.
//
// A load item writes one coefficient slot. A ray item walks the 35 stored coefficients; each
// nonzero one is expanded against four linear factors limb by limb through one
// shared 33x32 multiplier and one wide adder, while a zero coefficient is only
// fetched and skipped. The five terms are then saturated, and the result item
// waits in its output register until taken. The block takes no new item until
// the result has been taken.
module ray_quartic_coefficient_expand_core #(
  parameter int COEF_WIDTH = rqce_pkg::COEF_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rqce_in_if.sink    in_chan,
  rqce_out_if.source out_chan,
  rqce_cfg_if.sink   cfg_chan
);

  localparam int AW   = $clog2(rqce_pkg::NUM_COEFS);
  localparam int W    = rqce_pkg::ACC_W;
  localparam int TOPB = rqce_pkg::FRAC_DROP + rqce_pkg::OUT_W - 1;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;
  localparam logic [AW-1:0] LAST_N = AW'(rqce_pkg::NUM_COEFS - 1);

  rqce_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] n_r, n_nxt;
  logic [1:0]    f_r, f_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          part_r, part_nxt;
  logic [2:0]    limb_r, limb_nxt;
  logic          pv_r, pv_nxt;
  logic [2:0]    psh_r, psh_nxt;

  logic [rqce_pkg::COORD_W-1:0] org_r [3], org_nxt [3];
  logic [rqce_pkg::COORD_W-1:0] dir_r [3], dir_nxt [3];
  logic [W-1:0] p_r [rqce_pkg::TERM_N], p_nxt [rqce_pkg::TERM_N];
  logic [W-1:0] acc_r [rqce_pkg::TERM_N], acc_nxt [rqce_pkg::TERM_N];
  logic [W-1:0] t_r, t_nxt;
  logic [rqce_pkg::OUT_W-1:0] res_r [rqce_pkg::TERM_N], res_nxt [rqce_pkg::TERM_N];
  logic inside_r, inside_nxt;
  logic ovf_r, ovf_nxt;
  logic [rqce_pkg::NUM_COEFS-1:0] valid_r, valid_nxt;
  logic [rqce_pkg::TOL_W-1:0] tol_r;

  // Coefficient store.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COEF_WIDTH-1:0] ram_wdata;
  logic [COEF_WIDTH-1:0] ram_rdata;
  logic                  ram_re;

  rqce_ram #(.WIDTH(COEF_WIDTH), .DEPTH(rqce_pkg::NUM_COEFS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (n_r),
    .rdata (ram_rdata)
  );

  // Shared multiplier.
  logic                                mul_en;
  logic signed [rqce_pkg::LIMB_W:0]    mul_a;
  logic signed [rqce_pkg::COORD_W-1:0] mul_b;
  logic signed [rqce_pkg::PROD_W-1:0]  prod;

  rqce_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  function automatic logic [W-1:0] sel_term(input logic [W-1:0] arr [rqce_pkg::TERM_N],
                                            input logic [2:0] idx);
    logic [W-1:0] r;
    r = '0;
    for (int i = 0; i < rqce_pkg::TERM_N; i++) begin
      if (idx == 3'(i)) r = arr[i];
    end
    return r;
  endfunction

  // Operand selection for the limb product.
  logic [2:0]                   src_idx;
  logic [W-1:0]                 src_word;
  logic [rqce_pkg::LIMB_W-1:0]  limb_word;
  logic [2:0]                   limb_last;
  rqce_pkg::mono_var_t          var_sel;
  logic [rqce_pkg::COORD_W-1:0] o_sel, d_sel;

  assign src_idx   = part_r ? (k_r - 3'd1) : k_r;
  assign src_word  = sel_term(p_r, src_idx);
  assign limb_word = rqce_pkg::LIMB_W'(src_word >> {limb_r, 5'd0});
  assign limb_last = {1'b0, f_r} + 3'd1;
  assign var_sel   = rqce_pkg::MONO_VAR[n_r][f_r];

  always_comb begin
    case (var_sel)
      rqce_pkg::VX: begin o_sel = org_r[0]; d_sel = dir_r[0]; end
      rqce_pkg::VY: begin o_sel = org_r[1]; d_sel = dir_r[1]; end
      rqce_pkg::VZ: begin o_sel = org_r[2]; d_sel = dir_r[2]; end
      default:      begin o_sel = rqce_pkg::ONE_Q16; d_sel = '0; end
    endcase
  end

  // The top limb of a term carries its sign; the lower limbs are unsigned.
  assign mul_a = (limb_r == limb_last) ? {limb_word[rqce_pkg::LIMB_W-1], limb_word}
                                       : {1'b0, limb_word};
  assign mul_b = part_r ? d_sel : o_sel;

  logic [W-1:0] prod_ext, t_add;
  assign prod_ext = {{(W - rqce_pkg::PROD_W){prod[rqce_pkg::PROD_W-1]}}, prod};
  assign t_add    = t_r + (prod_ext << {psh_r, 5'd0});

  // Coefficient read back; a slot never loaded reads as zero.
  logic [COEF_WIDTH-1:0] coef_q;
  assign coef_q = valid_r[n_r] ? ram_rdata : '0;

  // Load-side saturation to the stored coefficient width.
  logic signed [63:0] cv64, cclamp;
  assign cv64   = 64'(in_chan.coef_value);
  assign cclamp = (cv64 > CMAX) ? CMAX : ((cv64 < CMIN) ? CMIN : cv64);

  // Floor to Q32.32 and saturate.
  logic [W-1:0]               fin_word;
  logic                       fin_ok;
  logic [rqce_pkg::OUT_W-1:0] fin_sat;
  assign fin_word = sel_term(acc_r, k_r);
  assign fin_ok   = (&fin_word[W-1:TOPB]) | ~(|fin_word[W-1:TOPB]);
  assign fin_sat  = fin_ok ? fin_word[TOPB:rqce_pkg::FRAC_DROP]
                           : (fin_word[W-1] ? rqce_pkg::SAT_MIN : rqce_pkg::SAT_MAX);

  logic in_acc;
  assign in_acc = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    f_nxt      = f_r;
    k_nxt      = k_r;
    part_nxt   = part_r;
    limb_nxt   = limb_r;
    pv_nxt     = 1'b0;
    psh_nxt    = psh_r;
    org_nxt    = org_r;
    dir_nxt    = dir_r;
    p_nxt      = p_r;
    acc_nxt    = acc_r;
    t_nxt      = pv_r ? t_add : t_r;
    res_nxt    = res_r;
    inside_nxt = inside_r;
    ovf_nxt    = ovf_r;
    valid_nxt  = valid_r;
    ram_we     = 1'b0;
    ram_waddr  = in_chan.coef_index[AW-1:0];
    ram_wdata  = cclamp[COEF_WIDTH-1:0];
    ram_re     = 1'b0;
    mul_en     = 1'b0;

    unique case (state_r)
      rqce_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.action == rqce_pkg::ACT_LOAD) begin
            if (in_chan.coef_index < 6'(rqce_pkg::NUM_COEFS)) begin
              ram_we = 1'b1;
              valid_nxt[in_chan.coef_index[AW-1:0]] = 1'b1;
            end
          end else begin
            org_nxt[0] = in_chan.origin_x;
            org_nxt[1] = in_chan.origin_y;
            org_nxt[2] = in_chan.origin_z;
            dir_nxt[0] = in_chan.dir_x;
            dir_nxt[1] = in_chan.dir_y;
            dir_nxt[2] = in_chan.dir_z;
            for (int i = 0; i < rqce_pkg::TERM_N; i++) acc_nxt[i] = '0;
            n_nxt     = '0;
            state_nxt = rqce_pkg::ST_FETCH;
          end
        end
      end
      rqce_pkg::ST_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = rqce_pkg::ST_COEF;
      end
      rqce_pkg::ST_COEF: begin
        if (coef_q == '0) begin
          if (n_r == LAST_N) begin
            k_nxt     = '0;
            state_nxt = rqce_pkg::ST_FIN;
          end else begin
            n_nxt     = n_r + AW'(1);
            state_nxt = rqce_pkg::ST_FETCH;
          end
        end else begin
          p_nxt[0] = {{(W - COEF_WIDTH){coef_q[COEF_WIDTH-1]}}, coef_q};
          for (int i = 1; i < rqce_pkg::TERM_N; i++) p_nxt[i] = '0;
          t_nxt     = '0;
          f_nxt     = '0;
          k_nxt     = 3'd1;
          part_nxt  = 1'b0;
          limb_nxt  = '0;
          state_nxt = rqce_pkg::ST_MUL;
        end
      end
      rqce_pkg::ST_MUL: begin
        mul_en  = 1'b1;
        pv_nxt  = 1'b1;
        psh_nxt = limb_r;
        if (limb_r == limb_last) begin
          limb_nxt = '0;
          if (!part_r && k_r != 3'd0) begin
            part_nxt = 1'b1;
          end else begin
            part_nxt  = 1'b0;
            state_nxt = rqce_pkg::ST_DRAIN;
          end
        end else begin
          limb_nxt = limb_r + 3'd1;
        end
      end
      rqce_pkg::ST_DRAIN: begin
        state_nxt = rqce_pkg::ST_WB;
      end
      rqce_pkg::ST_WB: begin
        for (int i = 0; i < rqce_pkg::TERM_N; i++) begin
          if (k_r == 3'(i)) p_nxt[i] = t_r;
        end
        t_nxt = '0;
        if (k_r == 3'd0) begin
          if (f_r == 2'd3) begin
            state_nxt = rqce_pkg::ST_ACC;
          end else begin
            f_nxt     = f_r + 2'd1;
            k_nxt     = {1'b0, f_r} + 3'd2;
            state_nxt = rqce_pkg::ST_MUL;
          end
        end else begin
          k_nxt     = k_r - 3'd1;
          state_nxt = rqce_pkg::ST_MUL;
        end
      end
      rqce_pkg::ST_ACC: begin
        for (int i = 0; i < rqce_pkg::TERM_N; i++) begin
          if (k_r == 3'(i)) acc_nxt[i] = acc_r[i] + p_r[i];
        end
        if (k_r == 3'(rqce_pkg::TERM_N - 1)) begin
          k_nxt = '0;
          if (n_r == LAST_N) begin
            state_nxt = rqce_pkg::ST_FIN;
          end else begin
            n_nxt     = n_r + AW'(1);
            state_nxt = rqce_pkg::ST_FETCH;
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      rqce_pkg::ST_FIN: begin
        for (int i = 0; i < rqce_pkg::TERM_N; i++) begin
          if (k_r == 3'(i)) res_nxt[i] = fin_sat;
        end
        if (k_r == 3'd0) begin
          ovf_nxt    = ~fin_ok;
          inside_nxt = $signed({fin_sat[rqce_pkg::OUT_W-1], fin_sat})
                       < $signed({32'd0, tol_r});
        end else begin
          ovf_nxt = ovf_r | ~fin_ok;
        end
        if (k_r == 3'(rqce_pkg::TERM_N - 1)) begin
          state_nxt = rqce_pkg::ST_OUT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      rqce_pkg::ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = rqce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rqce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqce_pkg::ST_IDLE;
      valid_r <= '0;
      pv_r    <= 1'b0;
      tol_r   <= rqce_pkg::TOL_RESET;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pv_r    <= pv_nxt;
      if (cfg_chan.valid) begin
        tol_r <= cfg_chan.inside_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    f_r      <= f_nxt;
    k_r      <= k_nxt;
    part_r   <= part_nxt;
    limb_r   <= limb_nxt;
    psh_r    <= psh_nxt;
    org_r    <= org_nxt;
    dir_r    <= dir_nxt;
    p_r      <= p_nxt;
    acc_r    <= acc_nxt;
    t_r      <= t_nxt;
    res_r    <= res_nxt;
    inside_r <= inside_nxt;
    ovf_r    <= ovf_nxt;
  end

  assign in_chan.ready           = (state_r == rqce_pkg::ST_IDLE);
  assign cfg_chan.ready          = 1'b1;
  assign out_chan.valid          = (state_r == rqce_pkg::ST_OUT);
  assign out_chan.quartic_term   = res_r[4];
  assign out_chan.cubic_term     = res_r[3];
  assign out_chan.quadratic_term = res_r[2];
  assign out_chan.linear_term    = res_r[1];
  assign out_chan.constant_term  = res_r[0];
  assign out_chan.inside_res     = inside_r;
  assign out_chan.overflow       = ovf_r;

endmodule
